// ----- design/mwtl_pkg.sv -----
// mwtl_pkg: shared types and constants for the median window / low-pass block.
// No dependencies; used by mwtl_ctrl, mwtl_dp and median_window_then_lowpass.

package mwtl_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int SMOOTH_W    = 20;
  localparam int WS_W        = 5;
  localparam int BW_W        = 9;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [WS_W-1:0] WS_RESET   = 5'd9;
  localparam logic [BW_W-1:0] BW_RESET   = 9'd51;
  localparam logic [BW_W-1:0] WEIGHT_ONE = 9'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_SCAN,
    S_CHECK,
    S_MUL,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_sample;
    logic cand_rd;
    logic scan;
    logic next_cand;
    logic prime;
    logic mul;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic win_close;
    logic scan_end;
    logic found;
    logic prime_due;
    logic out_free;
  } status_t;

endpackage

// ----- design/mwtl_ctrl.sv -----
// mwtl_ctrl: sequencer for sample capture, rank search, blend and output load.
// Depends on mwtl_pkg (state_t, cmd_t, status_t).

module mwtl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mwtl_pkg::status_t st,
  output mwtl_pkg::cmd_t    cmd
);

  mwtl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwtl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      mwtl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_sample = 1'b1;
          if (st.win_close) begin
            state_next = mwtl_pkg::S_CAND;
          end
        end
      end
      mwtl_pkg::S_CAND: begin
        cmd.cand_rd = 1'b1;
        state_next  = mwtl_pkg::S_SCAN;
      end
      mwtl_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_end) begin
          state_next = mwtl_pkg::S_CHECK;
        end
      end
      mwtl_pkg::S_CHECK: begin
        if (st.found) begin
          state_next = mwtl_pkg::S_MUL;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = mwtl_pkg::S_CAND;
        end
      end
      mwtl_pkg::S_MUL: begin
        if (st.prime_due) begin
          cmd.prime  = 1'b1;
          state_next = mwtl_pkg::S_IDLE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = mwtl_pkg::S_EMIT;
        end
      end
      mwtl_pkg::S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = mwtl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mwtl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mwtl_dp.sv -----
// mwtl_dp: config registers, window store, rank-count median search, blend and
// output register. Depends on mwtl_pkg; driven by mwtl_ctrl commands.

module mwtl_dp #(
  parameter int MAX_WINDOW = mwtl_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mwtl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwtl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [mwtl_pkg::SAMPLE_W-1:0]     sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mwtl_pkg::SMOOTH_W-1:0]     smoothed,
  output logic [mwtl_pkg::SAMPLE_W-1:0]     window_median,
  input  mwtl_pkg::cmd_t                    cmd,
  output mwtl_pkg::status_t                 st
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam logic [7:0] MAXW8 = 8'(MAX_WINDOW);

  logic [mwtl_pkg::WS_W-1:0]     window_size;
  logic [mwtl_pkg::BW_W-1:0]     blend_weight;
  logic [mwtl_pkg::SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [mwtl_pkg::SAMPLE_W-1:0] rd_data;
  logic [CW-1:0]                 fill;
  logic [CW-1:0]                 cand_idx;
  logic [CW-1:0]                 scan_idx;
  logic [CW-1:0]                 less_cnt;
  logic [CW-1:0]                 le_cnt;
  logic [mwtl_pkg::SAMPLE_W-1:0] cand;
  logic [mwtl_pkg::SAMPLE_W-1:0] prior;
  logic                          pending;
  logic signed [22:0]            prod;

  logic [7:0]                    ws_ext;
  logic [7:0]                    n8;
  logic [CW-1:0]                 n_eff;
  logic [CW-1:0]                 k_med;
  logic [CW-1:0]                 wr_idx;
  logic [mwtl_pkg::BW_W-1:0]     w_sat;
  logic signed [12:0]            diff;
  logic signed [23:0]            acc;

  // effective window: zero means one, clipped to the store depth
  assign ws_ext = 8'(window_size);
  assign n8     = (window_size == '0) ? 8'd1 : ((ws_ext > MAXW8) ? MAXW8 : ws_ext);
  assign n_eff  = n8[CW-1:0];
  assign k_med  = (n_eff - CW'(1)) >> 1;

  // a shrunk window overwrites its last slot
  assign wr_idx = (fill >= n_eff) ? (n_eff - CW'(1)) : fill;
  assign w_sat  = (blend_weight > mwtl_pkg::WEIGHT_ONE) ? mwtl_pkg::WEIGHT_ONE : blend_weight;
  assign diff   = $signed({1'b0, cand}) - $signed({1'b0, prior});
  assign acc    = $signed({4'b0, prior, 8'b0}) + $signed({prod[22], prod});

  assign st.win_close = ((wr_idx + CW'(1)) == n_eff);
  assign st.scan_end  = (scan_idx == n_eff);
  assign st.found     = ((less_cnt <= k_med) && (k_med < le_cnt))
                        || (cand_idx == (n_eff - CW'(1)));
  assign st.prime_due = (prior == '0) && !pending;
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= mwtl_pkg::WS_RESET;
      blend_weight <= mwtl_pkg::BW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwtl_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[mwtl_pkg::WS_W-1:0];
        mwtl_pkg::REG_BLEND_WEIGHT: blend_weight <= cfg_data[mwtl_pkg::BW_W-1:0];
        default: ;
      endcase
    end
  end

  // window store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_sample) begin
      mem[wr_idx[AW-1:0]] <= sample;
    end
    if (cmd.cand_rd) begin
      rd_data <= mem[cand_idx[AW-1:0]];
    end else if (cmd.scan && (scan_idx < n_eff)) begin
      rd_data <= mem[scan_idx[AW-1:0]];
    end
  end

  // search counters and rank tallies
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      cand_idx <= '0;
    end else begin
      if (cmd.wr_sample) begin
        fill <= st.win_close ? '0 : (wr_idx + CW'(1));
        if (st.win_close) begin
          cand_idx <= '0;
        end
      end
      if (cmd.next_cand) begin
        cand_idx <= cand_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_rd) begin
      scan_idx <= '0;
      less_cnt <= '0;
      le_cnt   <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + CW'(1);
      if (scan_idx == '0) begin
        cand <= rd_data;
      end else begin
        if (rd_data < cand) begin
          less_cnt <= less_cnt + CW'(1);
        end
        if (rd_data <= cand) begin
          le_cnt <= le_cnt + CW'(1);
        end
      end
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, w_sat}) * diff;
    end
  end

  // blend history and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prior     <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.prime) begin
        prior   <= cand;
        pending <= 1'b1;
      end
      if (cmd.emit) begin
        prior     <= cand;
        pending   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      smoothed      <= acc[mwtl_pkg::SMOOTH_W-1:0];
      window_median <= cand;
    end
  end

endmodule

// ----- design/median_window_then_lowpass.sv -----
// median_window_then_lowpass: top level, controller plus datapath.
// Depends on mwtl_pkg, mwtl_ctrl and mwtl_dp.

// Collects 12-bit ADC samples into windows of window_size (0 acts as 1,
// values above MAX_WINDOW clip to it), picks the lower median of each window
// and blends it with the previous window's median as
// w*new + (256-w)*old in Q12.8, w = blend_weight clipped to 256. The first
// window after reset, or after a stored zero median has been used, only
// primes the history and gives no beat. A closing sample starts a rank
// search over the window store, a memory with one write port and a
// registered read: for each candidate, one read fetches it, a scan reads
// the window and counts the smaller and the not-larger entries, and a
// check tests its rank; up to n candidates are tried, then come the
// multiply and the output load. in_ready is low during that time. The
// result sits in an output register, so the next window fills while a beat
// waits to be taken; only the final load waits for out_ready.

module median_window_then_lowpass #(
  parameter int MAX_WINDOW = mwtl_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mwtl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwtl_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample beats
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mwtl_pkg::SAMPLE_W-1:0]   sample,
  // result beats
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mwtl_pkg::SMOOTH_W-1:0]   smoothed,
  output logic [mwtl_pkg::SAMPLE_W-1:0]   window_median
);

  mwtl_pkg::cmd_t    cmd;
  mwtl_pkg::status_t st;

  // sequencer: capture, search, blend, load
  mwtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // store, rank counters, multiplier and output register
  mwtl_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .smoothed      (smoothed),
    .window_median (window_median),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// ----- tb/tb_median_window_then_lowpass.sv -----
// Self-checking testbench for median_window_then_lowpass: a directed script, then
// random phases, each result beat checked against an in-bench window/blend predictor.
// Depends on mwtl_pkg and the median_window_then_lowpass RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_median_window_then_lowpass;

  localparam int SAMPLE_W      = mwtl_pkg::SAMPLE_W;
  localparam int SMOOTH_W      = mwtl_pkg::SMOOTH_W;
  localparam int WS_W          = mwtl_pkg::WS_W;
  localparam int BW_W          = mwtl_pkg::BW_W;
  localparam int CFG_IDX_W     = mwtl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = mwtl_pkg::CFG_DATA_W;
  localparam int CLK_PERIOD    = 12;
  localparam int MAX_WIN       = mwtl_pkg::MAX_WINDOW_DEF;
  localparam int WIN_AW        = $clog2(MAX_WIN);
  // covers the worst rank search at n = 16, output load included
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_ITEMS  = 600;
  localparam int RX_HOLD       = 1500;
  localparam int LIMIT_CYCLES  = 1_500_000;
  localparam int IDLE_PCT      = 38;

  typedef struct packed {
    logic [SMOOTH_W-1:0] smoothed;
    logic [SAMPLE_W-1:0] median;
  } blend_t;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [SAMPLE_W-1:0]   smp;
    logic                  typed;
    blend_t                want;
  } script_row_t;

  // shapes of the random sample stream
  typedef enum int {SHAPE_SPREAD, SHAPE_CLUSTER, SHAPE_RAILS, SHAPE_ZEROS} shape_t;

  // every block input is known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [SAMPLE_W-1:0]   sample    = '0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [SMOOTH_W-1:0]   smoothed;
  logic [SAMPLE_W-1:0]   window_median;

  // predictor state: window contents, fill level, previous median, priming flag
  logic [SAMPLE_W-1:0] win_store [MAX_WIN];
  logic [WS_W-1:0]     win_fill;
  logic [SAMPLE_W-1:0] last_median;
  bit                  primed;
  logic [WS_W-1:0]     cur_ws;
  logic [BW_W-1:0]     cur_bw;

  blend_t      due_blends [$];   // blends owed by the block, oldest first
  script_row_t script [$];       // directed rows
  int          mismatches   = 0;
  int          tx_idle_pct  = IDLE_PCT;
  int          rx_idle_pct  = IDLE_PCT;
  bit          hold_request = 1'b0;

  median_window_then_lowpass u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .smoothed     (smoothed),
    .window_median(window_median)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // One accepted sample through the window. A closing sample sorts the window,
  // takes the lower median and either primes the history or yields a blend.
  task automatic step_filter(input logic [SAMPLE_W-1:0] s, output bit got, output blend_t res);
    int n;
    int w;
    int i;
    int j;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] med;
    logic [SAMPLE_W-1:0] sorted [MAX_WIN];
    got = 1'b0;
    res = '0;
    // zero acts as one; anything above the store depth clips to it
    n = (cur_ws == 0) ? 1 : ((int'(cur_ws) > MAX_WIN) ? MAX_WIN : int'(cur_ws));
    // size lowered mid-window: next sample overwrites the last slot and closes
    if (int'(win_fill) >= n) win_fill = WS_W'(n - 1);
    win_store[win_fill[WIN_AW-1:0]] = s;
    win_fill++;
    if (int'(win_fill) < n) return;
    win_fill = '0;
    for (i = 0; i < n; i++) begin
      v = win_store[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    med = sorted[(n - 1) / 2];
    // empty history: this window only primes
    if (last_median == '0 && !primed) begin
      last_median = med;
      primed = 1'b1;
      return;
    end
    w = (int'(cur_bw) > 256) ? 256 : int'(cur_bw);
    res.smoothed = SMOOTH_W'(w * int'(med) + (256 - w) * int'(last_median));
    res.median   = med;
    last_median  = med;
    primed       = 1'b0;
    got          = 1'b1;
  endtask

  // Offer one sample beat, with random idle cycles first, and book its result.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed, input blend_t want);
    bit     got;
    blend_t res;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    step_filter(s, got, res);
    if (typed) due_blends.push_back(want);
    else if (got) due_blends.push_back(res);
  endtask

  // Register write once the block has gone quiet: all blends delivered, then
  // long enough for a priming window's rank search to finish.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (due_blends.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mwtl_pkg::REG_WINDOW_SIZE) cur_ws = val[WS_W-1:0];
    else cur_bw = val[BW_W-1:0];
  endtask

  function automatic script_row_t sample_row(input logic [SAMPLE_W-1:0] s);
    script_row_t r;
    r      = '0;
    r.kind = ROW_SAMPLE;
    r.smp  = s;
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic [SAMPLE_W-1:0] s,
                                            input logic [SMOOTH_W-1:0] sm);
    script_row_t r;
    r               = sample_row(s);
    r.typed         = 1'b1;
    r.want.smoothed = sm;
    r.want.median   = s;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    script_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input shape_t shape, input int base);
    int v;
    case (shape)
      SHAPE_CLUSTER: v = base + int'($urandom_range(0, 80)) - 40;
      SHAPE_RAILS: begin
        v = int'($urandom_range(0, 99));
        v = (v < 40) ? 0 : ((v < 80) ? 4095 : int'($urandom_range(0, 4095)));
      end
      // mostly zero, so zero medians keep re-priming the history
      SHAPE_ZEROS: v = ($urandom_range(0, 99) < 75) ? 0 : int'($urandom_range(0, 4095));
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // Result side: each beat taken is compared with the oldest blend owed.
  always @(posedge clk) begin : check_results
    blend_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_blends.size() == 0) begin
        report_mismatch("result beat with no blend due", smoothed, 0);
      end else begin
        want = due_blends.pop_front();
        if (smoothed !== want.smoothed)
          report_mismatch("smoothed", smoothed, want.smoothed);
        if (window_median !== want.median)
          report_mismatch("window_median", window_median, want.median);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here when asked,
  // so that the output register and then the sample side back up.
  initial begin : receiver
    int k;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        for (k = 0; k < RX_HOLD; k++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("tb_median_window_then_lowpass NOT OK");
    $finish;
  end

  initial begin : stimulus
    script_row_t row;
    shape_t      shape;
    int          phase;
    int          sent;
    int          batch;
    int          base;
    int          r;
    int          k;
    logic [WS_W-1:0] ws;
    logic [BW_W-1:0] bw;

    // predictor starts from the reset values
    cur_ws      = mwtl_pkg::WS_RESET;
    cur_bw      = mwtl_pkg::BW_RESET;
    win_fill    = '0;
    last_median = '0;
    primed      = 1'b0;
    for (k = 0; k < MAX_WIN; k++) win_store[k] = '0;

    // Reset defaults (size 9): first window only primes, median 650.
    script.push_back(sample_row(12'd100));
    script.push_back(sample_row(12'd4095));
    script.push_back(sample_row(12'd0));
    script.push_back(sample_row(12'd7));
    script.push_back(sample_row(12'd3000));
    script.push_back(sample_row(12'd2500));
    script.push_back(sample_row(12'd12));
    script.push_back(sample_row(12'd800));
    script.push_back(sample_row(12'd650));
    // Single-sample windows at full weight: output is 256 times the sample.
    script.push_back(reg_row(mwtl_pkg::REG_WINDOW_SIZE, 9'd1));
    script.push_back(reg_row(mwtl_pkg::REG_BLEND_WEIGHT, 9'd256));
    script.push_back(typed_row(12'd4095, 20'd1048320));
    // a zero median is stored, so the window after it primes again
    script.push_back(typed_row(12'd0, 20'd0));
    script.push_back(sample_row(12'd4095));
    // zero weight: all of the old median
    script.push_back(reg_row(mwtl_pkg::REG_BLEND_WEIGHT, 9'd0));
    script.push_back(typed_row(12'd1, 20'd1048320));
    // weight above 256 saturates
    script.push_back(reg_row(mwtl_pkg::REG_BLEND_WEIGHT, 9'd511));
    script.push_back(typed_row(12'd2048, 20'd524288));
    // window size zero behaves as one
    script.push_back(reg_row(mwtl_pkg::REG_WINDOW_SIZE, 9'd0));
    script.push_back(typed_row(12'd2730, 20'd698880));
    script.push_back(typed_row(12'd1365, 20'd349440));
    // size lowered with three samples held: the next one closes a window of two
    script.push_back(reg_row(mwtl_pkg::REG_WINDOW_SIZE, 9'd4));
    script.push_back(sample_row(12'd300));
    script.push_back(sample_row(12'd4000));
    script.push_back(sample_row(12'd150));
    script.push_back(reg_row(mwtl_pkg::REG_WINDOW_SIZE, 9'd2));
    script.push_back(sample_row(12'd900));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      row = script[k];
      if (row.kind == ROW_REG) write_reg(row.idx, row.val);
      else send_sample(row.smp, row.typed, row.want);
    end

    // Random phases: fresh settings, then a burst of samples of one shape.
    // Burst lengths rarely fill whole windows, so settings often change
    // mid-window.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      r  = int'($urandom_range(0, 99));
      ws = (r < 70) ? WS_W'($urandom_range(1, 9)) :
           (r < 80) ? WS_W'($urandom_range(10, 16)) :
           (r < 88) ? WS_W'(0) : WS_W'($urandom_range(17, 31));
      r  = int'($urandom_range(0, 99));
      bw = (r < 15) ? BW_W'(0) :
           (r < 30) ? BW_W'(256) :
           (r < 40) ? BW_W'($urandom_range(257, 511)) : BW_W'($urandom_range(0, 255));
      batch = int'($urandom_range(12, 48));
      r     = int'($urandom_range(0, 9));
      shape = (r < 4) ? SHAPE_SPREAD : (r < 6) ? SHAPE_CLUSTER :
              (r < 8) ? SHAPE_RAILS : SHAPE_ZEROS;
      case (phase)
        0: ws = WS_W'(16);      // largest window
        1: ws = WS_W'(31);      // clips to the largest window
        2: begin                // back-pressure: one result per beat
          ws    = WS_W'(1);
          batch = 40;
          shape = SHAPE_SPREAD;
        end
        3: batch = 60;          // no idling on either side
        default: ;
      endcase
      write_reg(mwtl_pkg::REG_WINDOW_SIZE, CFG_DATA_W'(ws));
      write_reg(mwtl_pkg::REG_BLEND_WEIGHT, CFG_DATA_W'(bw));
      if (phase == 2) begin
        tx_idle_pct  = 0;
        hold_request = 1'b1;
      end
      if (phase == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      base = int'($urandom_range(0, 4095));
      for (k = 0; k < batch; k++) begin
        send_sample(pick_sample(shape, base), 1'b0, '0);
      end
      tx_idle_pct = IDLE_PCT;
      rx_idle_pct = IDLE_PCT;
      sent += batch;
      phase++;
    end

    // drain: every blend delivered, then room for a late stray beat
    in_valid <= 1'b0;
    while (due_blends.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_median_window_then_lowpass OK");
    end else begin
      $display("tb_median_window_then_lowpass NOT OK");
    end
    $finish;
  end

endmodule
